/* hw/rtl/pkhwd_pkg.sv */
package pkhwd_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int USED_W      = 6;

  typedef logic [31:0]        key_t;
  typedef logic signed [63:0] stamp_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_MERGE = 2'd2,
    OP_PROBE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic ins;
    logic upd;
  } cell_wr_t;

  typedef struct packed {
    logic hit;
    logic gt;
  } cell_flag_t;

endpackage

/* hw/rtl/pkhwd_if.sv */
interface pkhwd_in_if import pkhwd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  key_t       record_key;
  stamp_t     record_time;

  modport source (output valid, op, record_key, record_time, input ready);
  modport sink   (input valid, op, record_key, record_time, output ready);
endinterface

interface pkhwd_out_if import pkhwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              append;
  logic              duplicate;
  logic              tracked;
  logic [USED_W-1:0] entries_used;

  modport source (output valid, append, duplicate, tracked, entries_used, input ready);
  modport sink   (input valid, append, duplicate, tracked, entries_used, output ready);
endinterface

/* hw/rtl/pkhwd_cell.sv */
module pkhwd_cell import pkhwd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cnt_t       cell_idx_i,
  input  cnt_t       count_i,
  input  key_t       key_i,
  input  stamp_t     time_i,
  input  cell_wr_t   wr_i,
  output cell_flag_t flag_o
);

  key_t       key_q;
  stamp_t     max_q;
  cell_flag_t flag_q, flag_d;
  logic       occupied;

  assign occupied = cell_idx_i < count_i;

  always_comb begin
    flag_d.hit = occupied && (key_q == key_i);
    flag_d.gt  = time_i > max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
    end else begin
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.ins && (cell_idx_i == count_i)) begin
      key_q <= key_i;
      max_q <= time_i;
    end else if (wr_i.upd && flag_q.hit) begin
      max_q <= time_i;
    end
  end

  assign flag_o = flag_q;

endmodule

/* hw/rtl/pkhwd_reduce.sv */
module pkhwd_reduce import pkhwd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [TABLE_DEPTH-1:0] hit_i,
  input  logic [TABLE_DEPTH-1:0] gt_i,
  output cell_flag_t             flag_o
);

  cell_flag_t flag_q, flag_d;

  always_comb begin
    flag_d.hit = |hit_i;
    flag_d.gt  = |(hit_i & gt_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign flag_o = flag_q;

endmodule

/* hw/rtl/per_key_high_water_dedup.sv */
// channel  dir  beat fields
// in_i     in   op, record_key, record_time
// out_o    out  append, duplicate, tracked, entries_used
//
// one item at a time: capture, cell compare, hit reduce, table update; a new item is taken only after the update
// the update waits while a previous result is still held in the output register
// reset empties the table (count to zero), cell contents are left as they are
// no clearing pass, the block takes an item right after reset
module per_key_high_water_dedup import pkhwd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pkhwd_in_if.sink      in_i,
  pkhwd_out_if.source   out_o
);

  state_e state_q, state_d;
  op_e    op_q;
  key_t   key_q;
  stamp_t time_q;
  cnt_t   count_q, count_d;

  logic              out_valid_q, out_valid_d;
  logic              append_q, append_d;
  logic              dup_q, dup_d;
  logic              trk_q, trk_d;

  cell_wr_t               wr;
  cell_flag_t             red_flag;
  cell_flag_t             cell_flag [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit_vec, gt_vec;
  logic                   accept, room, upd_go;

  assign accept = in_i.valid && in_i.ready;
  assign room   = count_q < cnt_t'(TABLE_DEPTH);
  assign upd_go = (state_q == ST_UPD) && (!out_valid_q || out_o.ready);

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    pkhwd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (cnt_t'(g)),
      .count_i    (count_q),
      .key_i      (key_q),
      .time_i     (time_q),
      .wr_i       (wr),
      .flag_o     (cell_flag[g])
    );
    assign hit_vec[g] = cell_flag[g].hit;
    assign gt_vec[g]  = cell_flag[g].gt;
  end

  pkhwd_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hit_i  (hit_vec),
    .gt_i   (gt_vec),
    .flag_o (red_flag)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;
    append_d    = append_q;
    dup_d       = dup_q;
    trk_d       = trk_q;
    wr          = '0;
    in_i.ready  = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CMP;
      end
      ST_CMP: state_d = ST_RED;
      ST_RED: state_d = ST_UPD;
      ST_UPD: begin
        if (upd_go) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          append_d    = 1'b0;
          dup_d       = 1'b0;
          trk_d       = 1'b0;
          case (op_q)
            OP_CLEAR: count_d = '0;
            OP_LOAD: begin
              if (red_flag.hit) begin
                wr.upd = red_flag.gt;
                trk_d  = 1'b1;
              end else if (room) begin
                wr.ins  = 1'b1;
                count_d = count_q + cnt_t'(1);
                trk_d   = 1'b1;
              end
            end
            OP_MERGE: begin
              if (red_flag.hit && !red_flag.gt) begin
                dup_d = 1'b1;
                trk_d = 1'b1;
              end else begin
                append_d = 1'b1;
                if (red_flag.hit) begin
                  wr.upd = 1'b1;
                  trk_d  = 1'b1;
                end else if (room) begin
                  wr.ins  = 1'b1;
                  count_d = count_q + cnt_t'(1);
                  trk_d   = 1'b1;
                end
              end
            end
            default: trk_d = red_flag.hit;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(in_i.op);
      key_q  <= in_i.record_key;
      time_q <= in_i.record_time;
    end
    append_q <= append_d;
    dup_q    <= dup_d;
    trk_q    <= trk_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.append       = append_q;
  assign out_o.duplicate    = dup_q;
  assign out_o.tracked      = trk_q;
  assign out_o.entries_used = USED_W'(count_q);

endmodule

/* hw/rtl/pkhwd_checker.sv */
module pkhwd_checker import pkhwd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              append_i,
  input logic              duplicate_i,
  input logic              tracked_i,
  input logic [USED_W-1:0] entries_used_i
);

  // a result is never both appended and dropped
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(append_i && duplicate_i))
    else $error("append and duplicate both set");

  // a duplicate always refers to a stored key
  a_dup_trk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && duplicate_i) |-> tracked_i)
    else $error("duplicate without tracked");

  // one item in flight at a time
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while an item is in flight");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(append_i)
      && $stable(duplicate_i) && $stable(tracked_i) && $stable(entries_used_i)))
    else $error("stalled result changed");

endmodule

bind per_key_high_water_dedup pkhwd_checker u_pkhwd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .append_i       (out_o.append),
  .duplicate_i    (out_o.duplicate),
  .tracked_i      (out_o.tracked),
  .entries_used_i (out_o.entries_used)
);
